// ----- design/srsc_pkg.sv -----
// Shared types and constants of the sorted record stream checker.
`timescale 1ns / 1ps

package srsc_pkg;

  localparam int OUT_W = 40;
  localparam int RLEN_W = 16;
  localparam int KLEN_W = 7;

  localparam logic [7:0] CFG_RECORD_LENGTH = 8'd0;
  localparam logic [7:0] CFG_KEY_LENGTH    = 8'd1;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LESS    = 2'd1,
    ORD_GREATER = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    VERDICT_PASS      = 2'd0,
    VERDICT_VIOLATION = 2'd1,
    VERDICT_PARTIAL   = 2'd2,
    VERDICT_BAD_SIZES = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [RLEN_W-1:0] record_length;
    logic [KLEN_W-1:0] key_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last;
    logic       bad;
    logic       key_hit;
    logic       rec_end;
    logic       partial;
  } item_t;

  typedef struct packed {
    verdict_t         verdict;
    logic [OUT_W-1:0] violation_record;
    logic [OUT_W-1:0] record_total;
  } result_t;

endpackage

// ----- design/srsc_key_mem.sv -----
// Previous-key store: registered read, write at the address last read, with forwarding.
`timescale 1ns / 1ps

module srsc_key_mem #(
  parameter int KEY_MAX = 64,
  parameter int KA = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [KA-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [7:0]    wr_data,
  output logic [7:0]    key_byte
);

  logic [7:0]    mem [KEY_MAX];
  logic [7:0]    rd_data_r;
  logic [KA-1:0] addr_r;
  logic          fwd_hit_r;
  logic [7:0]    fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      addr_r     <= rd_addr;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (rd_addr == addr_r);
    end
  end

  assign key_byte = fwd_hit_r ? fwd_data_r : rd_data_r;

endmodule

// ----- design/srsc_front.sv -----
// Byte position tracking, size check and the compare-stage item register.
`timescale 1ns / 1ps

module srsc_front #(
  parameter int KEY_MAX = 64,
  parameter int KA = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srsc_pkg::cfg_t       cfg,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 stream_end,
  input  logic                 advance,
  output logic [KA-1:0]        rd_addr,
  output srsc_pkg::item_t      item
);
  import srsc_pkg::*;

  logic [RLEN_W-1:0] pos_r;
  logic [RLEN_W-1:0] pos_nxt;
  item_t             item_r;
  item_t             item_nxt;
  logic              bad;
  logic              key_hit;
  logic              rec_end;

  always_comb begin
    bad = (cfg.record_length == '0) || (cfg.key_length == '0) ||
          (RLEN_W'(cfg.key_length) > cfg.record_length) ||
          (9'(cfg.key_length) > 9'(KEY_MAX));
    key_hit = (RLEN_W'(pos_r) < RLEN_W'(cfg.key_length)) &&
              ({1'b0, pos_r} < 17'(KEY_MAX));
    rec_end = ({1'b0, pos_r} + 17'd1) >= {1'b0, cfg.record_length};
    rd_addr = pos_r[KA-1:0];

    pos_nxt = pos_r;
    if (accept) begin
      if (stream_end) begin
        pos_nxt = '0;
      end else if (!bad) begin
        pos_nxt = rec_end ? '0 : pos_r + RLEN_W'(1);
      end
    end

    item_nxt = item_r;
    if (accept) begin
      item_nxt.valid     = 1'b1;
      item_nxt.data_byte = data_byte;
      item_nxt.last      = stream_end;
      item_nxt.bad       = bad;
      item_nxt.key_hit   = key_hit;
      item_nxt.rec_end   = rec_end;
      item_nxt.partial   = !rec_end;
    end else if (advance) begin
      item_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      item_r.valid <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      item_r <= item_nxt;
    end
  end

  assign item = item_r;

endmodule

// ----- design/srsc_judge.sv -----
// Key compare, record counting, first violation capture and verdict forming.
`timescale 1ns / 1ps

module srsc_judge #(
  parameter int INDEX_BITS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srsc_pkg::item_t    item,
  input  logic               advance,
  input  logic [7:0]         key_byte,
  output logic               wr_en,
  output srsc_pkg::result_t  result
);
  import srsc_pkg::*;

  order_t                ord_r;
  order_t                ord_nxt;
  order_t                ord_cmp;
  logic [INDEX_BITS-1:0] rec_idx_r;
  logic [INDEX_BITS-1:0] rec_idx_nxt;
  logic                  viol_r;
  logic                  viol_nxt;
  logic [INDEX_BITS-1:0] first_r;
  logic [INDEX_BITS-1:0] first_nxt;
  logic                  cmp_en;

  always_comb begin
    cmp_en = item.key_hit && !item.bad && (rec_idx_r != '0) && (ord_r == ORD_EQUAL);
    wr_en  = advance && item.key_hit && !item.bad;

    ord_cmp = ord_r;
    if (cmp_en) begin
      if (key_byte > item.data_byte) begin
        ord_cmp = ORD_GREATER;
      end else if (key_byte < item.data_byte) begin
        ord_cmp = ORD_LESS;
      end
    end

    ord_nxt     = ord_r;
    rec_idx_nxt = rec_idx_r;
    viol_nxt    = viol_r;
    first_nxt   = first_r;
    if (advance && !item.bad) begin
      if (item.rec_end) begin
        if ((rec_idx_r != '0) && (ord_cmp == ORD_GREATER) && !viol_r) begin
          viol_nxt  = 1'b1;
          first_nxt = rec_idx_r;
        end
        if (rec_idx_r != '1) begin
          rec_idx_nxt = rec_idx_r + INDEX_BITS'(1);
        end
        ord_nxt = ORD_EQUAL;
      end else begin
        ord_nxt = ord_cmp;
      end
    end

    result.violation_record = '0;
    result.record_total     = OUT_W'(rec_idx_nxt);
    priority if (item.bad) begin
      result.verdict = VERDICT_BAD_SIZES;
    end else if (item.partial) begin
      result.verdict = VERDICT_PARTIAL;
    end else if (viol_nxt) begin
      result.verdict          = VERDICT_VIOLATION;
      result.violation_record = OUT_W'(first_nxt);
    end else begin
      result.verdict = VERDICT_PASS;
    end

    if (advance && item.last) begin
      ord_nxt     = ORD_EQUAL;
      rec_idx_nxt = '0;
      viol_nxt    = 1'b0;
      first_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r     <= ORD_EQUAL;
      rec_idx_r <= '0;
      viol_r    <= 1'b0;
      first_r   <= '0;
    end else begin
      ord_r     <= ord_nxt;
      rec_idx_r <= rec_idx_nxt;
      viol_r    <= viol_nxt;
      first_r   <= first_nxt;
    end
  end

`ifndef SYNTH
  a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !viol_r |-> first_r == '0)
    else $error("first violation index set without a violation");
  a_no_viol_first: assert property (@(posedge clk) disable iff (!rst_n)
    rec_idx_r == '0 |-> !viol_r)
    else $error("violation flagged before any complete record");
  a_first_bound: assert property (@(posedge clk) disable iff (!rst_n)
    viol_r |-> first_r <= rec_idx_r)
    else $error("first violation index beyond record count");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.last |=> rec_idx_r == '0 && !viol_r && ord_r == ORD_EQUAL)
    else $error("stream state not cleared after the final byte");
`endif

endmodule

// ----- design/sorted_record_stream_checker.sv -----
// Top level of the sorted record stream checker.
`timescale 1ns / 1ps

// Accepts one stream byte per clock on the in_ channel and checks that each
// record's key is not less than the key of the record before it. A byte is
// read against the key store in the cycle of its transfer and compared and
// written back in the next, with forwarding when consecutive bytes hit the
// same key position, so the sustained rate is one byte per cycle. Only the
// byte marked with in_tlast gives a result, formed at the compare stage; the
// input stalls only while that result cannot yet move into the occupied
// output register. Registers are written through the cfg_ channel, which is
// always ready, and should only be changed while no stream is in flight.
// Key bytes of the store are undefined until the first record of a stream
// has written them; no clearing pass is needed after reset.
module sorted_record_stream_checker #(
  parameter int KEY_MAX = 64,
  parameter int INDEX_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // verdict[1:0], violation_record[41:2],
                                  // record_total[81:42], zero padding[87:82]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import srsc_pkg::*;

  localparam int KA = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  cfg_t          cfg_r;
  item_t         item;
  result_t       result;
  result_t       out_r;
  logic          out_valid_r;
  logic          stall;
  logic          advance;
  logic          accept;
  logic [KA-1:0] rd_addr;
  logic          wr_en;
  logic [7:0]    key_byte;

  assign cfg_ready = 1'b1;
  assign stall     = item.valid && item.last && out_valid_r && !out_tready;
  assign advance   = item.valid && !stall;
  assign in_tready = !stall;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.record_length <= RLEN_W'(100);
      cfg_r.key_length    <= KLEN_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RECORD_LENGTH: cfg_r.record_length <= cfg_data;
        CFG_KEY_LENGTH:    cfg_r.key_length    <= cfg_data[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  srsc_front #(
    .KEY_MAX(KEY_MAX),
    .KA(KA)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .accept(accept),
    .data_byte(in_tdata),
    .stream_end(in_tlast),
    .advance(advance),
    .rd_addr(rd_addr),
    .item(item)
  );

  srsc_key_mem #(
    .KEY_MAX(KEY_MAX),
    .KA(KA)
  ) u_key_mem (
    .clk(clk),
    .rst_n(rst_n),
    .rd_en(accept),
    .rd_addr(rd_addr),
    .wr_en(wr_en),
    .wr_data(item.data_byte),
    .key_byte(key_byte)
  );

  srsc_judge #(
    .INDEX_BITS(INDEX_BITS)
  ) u_judge (
    .clk(clk),
    .rst_n(rst_n),
    .item(item),
    .advance(advance),
    .key_byte(key_byte),
    .wr_en(wr_en),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && item.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.record_total, out_r.violation_record, out_r.verdict};

endmodule
